// File: sv/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// invariant, disabled in reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("invariant check failed");

`endif

// File: sv/hen_pkg.sv
// types, codes and character tables for the html escape / paragraph block
// no dependencies; used by every module of the block
package hen_pkg;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_QUOT = 8'h22;

	// replacement texts, left aligned in six character slots
	localparam logic [47:0] PARA_TXT = {"<p>", 24'h000000};
	localparam logic [47:0] AMP_TXT  = {"&amp;", 8'h00};
	localparam logic [47:0] LT_TXT   = {"&lt;", 16'h0000};
	localparam logic [47:0] GT_TXT   = {"&gt;", 16'h0000};
	localparam logic [47:0] QUOT_TXT = "&quot;";

	localparam int QUEUE_DEPTH = 2;

	// held newline kind
	typedef enum logic [1:0] {
		NL_NONE = 2'd0,
		NL_LF   = 2'd1,
		NL_CR   = 2'd2
	} nl_t;

	// what the byte of an item turns into, after any paragraph prefix
	typedef enum logic [2:0] {
		BODY_NONE = 3'd0,
		BODY_PARA = 3'd1,
		BODY_AMP  = 3'd2,
		BODY_LT   = 3'd3,
		BODY_GT   = 3'd4,
		BODY_QUOT = 3'd5,
		BODY_BYTE = 3'd6
	} body_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        prefix;
		body_t       body;
		logic [7:0]  data;
		logic        last;
		logic [3:0]  len;
	} desc_t;

	// queue status seen by the top level, which passes the empty flag to the back end
	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} qstat_t;

	function automatic logic [3:0] body_len(body_t body);
		logic [3:0] n;
		unique case (body)
			BODY_NONE: n = 4'd0;
			BODY_PARA: n = 4'd3;
			BODY_AMP:  n = 4'd5;
			BODY_LT:   n = 4'd4;
			BODY_GT:   n = 4'd4;
			BODY_QUOT: n = 4'd6;
			BODY_BYTE: n = 4'd1;
			default:   n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] txt_char(logic [47:0] txt, logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = txt[47:40];
			3'd1:    c = txt[39:32];
			3'd2:    c = txt[31:24];
			3'd3:    c = txt[23:16];
			3'd4:    c = txt[15:8];
			3'd5:    c = txt[7:0];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] body_char(body_t body, logic [2:0] idx, logic [7:0] data);
		logic [7:0] c;
		unique case (body)
			BODY_PARA: c = txt_char(PARA_TXT, idx);
			BODY_AMP:  c = txt_char(AMP_TXT, idx);
			BODY_LT:   c = txt_char(LT_TXT, idx);
			BODY_GT:   c = txt_char(GT_TXT, idx);
			BODY_QUOT: c = txt_char(QUOT_TXT, idx);
			BODY_BYTE: c = data;
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: sv/hen_front.sv
// front end: accepts text items, merges newline pairs and classifies each byte
// depends on hen_pkg
module hen_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               escape,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               last_byte,
	output logic               q_push,
	output hen_pkg::desc_t     q_desc
);

	hen_pkg::nl_t pend_q;
	hen_pkg::nl_t pend_d;
	logic         is_lf;
	logic         is_cr;
	logic         held;
	logic         merged;
	hen_pkg::body_t body;

	// classify the byte against the held newline
	always_comb begin
		is_lf  = (in_byte == hen_pkg::CH_LF);
		is_cr  = (in_byte == hen_pkg::CH_CR);
		held   = (pend_q == hen_pkg::NL_LF) || (pend_q == hen_pkg::NL_CR);
		merged = ((pend_q == hen_pkg::NL_LF) && is_cr) || ((pend_q == hen_pkg::NL_CR) && is_lf);
		pend_d = hen_pkg::NL_NONE;
		body   = hen_pkg::BODY_BYTE;
		if (merged) begin
			body = hen_pkg::BODY_NONE;
		end else if (is_lf || is_cr) begin
			if (last_byte) begin
				body = hen_pkg::BODY_PARA;
			end else begin
				body   = hen_pkg::BODY_NONE;
				pend_d = is_lf ? hen_pkg::NL_LF : hen_pkg::NL_CR;
			end
		end else if (escape) begin
			case (in_byte)
				hen_pkg::CH_AMP:  body = hen_pkg::BODY_AMP;
				hen_pkg::CH_LT:   body = hen_pkg::BODY_LT;
				hen_pkg::CH_GT:   body = hen_pkg::BODY_GT;
				hen_pkg::CH_QUOT: body = hen_pkg::BODY_QUOT;
				default:          body = hen_pkg::BODY_BYTE;
			endcase
		end
	end

	// descriptor toward the queue; items that only hold a newline are dropped here
	always_comb begin
		q_desc.prefix = held;
		q_desc.body   = body;
		q_desc.data   = in_byte;
		q_desc.last   = last_byte;
		q_desc.len    = (held ? 4'd3 : 4'd0) + hen_pkg::body_len(body);
		q_push        = accept && (q_desc.len != 4'd0);
	end

	// held newline state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= hen_pkg::NL_NONE;
		end else if (accept) begin
			pend_q <= pend_d;
		end
	end

endmodule

// File: sv/hen_queue.sv
// short descriptor queue between the front and back ends
// depends on hen_pkg
module hen_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hen_pkg::desc_t     push_desc,
	input  logic               pop,
	output hen_pkg::desc_t     head,
	output hen_pkg::qstat_t    stat
);

	localparam logic [1:0] DEPTH = 2'(hen_pkg::QUEUE_DEPTH);

	hen_pkg::desc_t entry_q [0:hen_pkg::QUEUE_DEPTH-1];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	always_comb begin
		stat.count = count_q;
		stat.empty = (count_q == 2'd0);
		stat.full  = (count_q == DEPTH);
		do_push    = push && !stat.full;
		do_pop     = pop && !stat.empty;
		head       = entry_q[rd_ptr_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_desc;
	end

endmodule

// File: sv/hen_back.sv
// back end: expands one descriptor into its result bytes, one per cycle while the receiver pops
// depends on hen_pkg
module hen_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hen_pkg::desc_t     head,
	input  logic               head_valid,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               last_of_run,
	output logic               end_of_text
);

	logic [3:0] pos_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       text_end_q;
	logic       load;
	logic       at_end;
	logic [3:0] body_pos;
	logic [7:0] chr;

	// pick the byte at the current position of the head descriptor
	always_comb begin
		load     = head_valid && (!out_valid_q || pop);
		at_end   = (pos_q == head.len - 4'd1);
		body_pos = pos_q - (head.prefix ? 4'd3 : 4'd0);
		if (head.prefix && (pos_q < 4'd3)) begin
			chr = hen_pkg::txt_char(hen_pkg::PARA_TXT, pos_q[2:0]);
		end else begin
			chr = hen_pkg::body_char(head.body, body_pos[2:0], head.data);
		end
		q_pop = load && at_end;
	end

	// position within the descriptor and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q       <= at_end ? 4'd0 : pos_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= chr;
			run_end_q  <= at_end;
			text_end_q <= at_end && head.last;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = run_end_q;
	assign end_of_text = text_end_q;

endmodule

// File: sv/html_escape_newline_to_paragraph_top.sv
// Text rewriter: html entity escaping and newline-to-paragraph conversion.
// Input channel: push/full; one text byte per item with last_byte marking the
// end of the text. An item is taken when push is high and full is low.
// Result channel: empty/pop; each result is one rewritten byte with
// last_of_run on the final byte caused by an item and end_of_text on the
// final byte of the text. A byte is taken when pop is high and empty is low.
// Config: APB write of escape_html at addresses 0 to 3 (bit 0), readable back.
// An accepted item is written into the descriptor queue and its first byte then
// loads into the output register. An item yields 0 to 9 bytes; the back end
// emits one byte per cycle while the receiver keeps popping, so plain bytes run
// at one item per cycle and an expanding item holds the back end until all of
// its bytes are loaded. A held newline produces nothing until the next item.
// The two-entry descriptor queue sets how far the front runs ahead; full
// rises when it is filled and the back end is still expanding.
// When the receiver stalls the output byte holds and the queue fills.
// Reset clears the queue, the held newline and sets escape_html to 1.
// depends on hen_pkg, hen_front, hen_queue, hen_back, assert_macros.svh
`include "assert_macros.svh"
module html_escape_newline_to_paragraph_top (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	// result items
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        end_of_text,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic             escape_q;
	logic             accept;
	logic             q_push;
	logic             q_pop;
	hen_pkg::desc_t   push_desc;
	hen_pkg::desc_t   head;
	hen_pkg::qstat_t  qstat;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			escape_q <= pwdata[0];
		end
	end
	assign prdata = paddr[2] ? 32'd0 : {31'd0, escape_q};

	// input handshake
	assign full   = qstat.full;
	assign accept = push && !full;

	hen_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.escape    (escape_q),
		.accept    (accept),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.q_push    (q_push),
		.q_desc    (push_desc)
	);

	hen_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.head      (head),
		.stat      (qstat)
	);

	hen_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!qstat.empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text)
	);

	// queue never holds more than its depth
	`ASSERT_ALWAYS(a_qcount, clk, arst_n, qstat.count <= 2'(hen_pkg::QUEUE_DEPTH))
	// end of text only on the last byte of a run
	`ASSERT_IMPLIES(a_eot_run, clk, arst_n, !empty && end_of_text, last_of_run)
	// a waiting descriptor reaches an empty output register next cycle
	`ASSERT_NEXT(a_fill, clk, arst_n, !qstat.empty && empty, !empty)
	// the queue only pops while the output side is free to load
	`ASSERT_IMPLIES(a_pop_ok, clk, arst_n, q_pop, !qstat.empty && (empty || pop))

endmodule

// File: bench/testbench.sv
// testbench for html_escape_newline_to_paragraph_top: entity escaping and newline to <p>
// predicts each rewritten byte on item acceptance and checks every popped result byte
// depends on hen_pkg and the html_escape_newline_to_paragraph_top rtl
module testbench;

	localparam logic [2:0] ESCAPE_ADDR = 3'd0;
	localparam logic [2:0] UNUSED_ADDR = 3'd4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_STALL = 80;

	// one expected result byte
	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       text_end;
	} out_rec_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  in_byte;
	logic        last_byte;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        end_of_text;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor state and expected result bytes
	out_rec_t      expected_bytes[$];
	hen_pkg::nl_t  held_nl;
	logic          esc_on;
	int            mismatches;

	// idling controls
	logic tx_idle_on;
	logic rx_idle_on;
	int   stall_req;
	int   stall_left;
	int   quiet_cycles;

	html_escape_newline_to_paragraph_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.end_of_text(end_of_text),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic report(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// expected byte queue helpers
	task automatic add_text(input string s, inout int n);
		for (int i = 0; i < s.len(); i++) begin
			expected_bytes.push_back('{ch: s[i], run_end: 1'b0, text_end: 1'b0});
			n++;
		end
	endtask

	task automatic handle_byte(input logic [7:0] b, input logic fin, inout int n);
		if (b == hen_pkg::CH_LF || b == hen_pkg::CH_CR) begin
			if (fin)
				add_text("<p>", n);
			else
				held_nl = (b == hen_pkg::CH_LF) ? hen_pkg::NL_LF : hen_pkg::NL_CR;
		end else if (esc_on && b == hen_pkg::CH_AMP) begin
			add_text("&amp;", n);
		end else if (esc_on && b == hen_pkg::CH_LT) begin
			add_text("&lt;", n);
		end else if (esc_on && b == hen_pkg::CH_GT) begin
			add_text("&gt;", n);
		end else if (esc_on && b == hen_pkg::CH_QUOT) begin
			add_text("&quot;", n);
		end else begin
			expected_bytes.push_back('{ch: b, run_end: 1'b0, text_end: 1'b0});
			n++;
		end
	endtask

	// rewrite one accepted item into its expected result bytes
	task automatic predict_rewrite(input logic [7:0] b, input logic fin);
		int            n;
		hen_pkg::nl_t  held;
		out_rec_t      tail;
		n = 0;
		held = held_nl;
		held_nl = hen_pkg::NL_NONE;
		if (held == hen_pkg::NL_LF || held == hen_pkg::NL_CR) begin
			add_text("<p>", n);
			// a partner newline merges into the same paragraph
			if (!((held == hen_pkg::NL_LF && b == hen_pkg::CH_CR)
				|| (held == hen_pkg::NL_CR && b == hen_pkg::CH_LF)))
				handle_byte(b, fin, n);
		end else begin
			handle_byte(b, fin, n);
		end
		if (fin)
			held_nl = hen_pkg::NL_NONE;
		if (n > 0) begin
			tail = expected_bytes.pop_back();
			tail.run_end = 1'b1;
			tail.text_end = fin;
			expected_bytes.push_back(tail);
		end
	endtask

	// send one item, with an optional idle burst in front
	task automatic send_item(input logic [7:0] b, input logic fin);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_rewrite(b, fin);
	endtask

	// about half special characters and newlines, the rest any byte
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 11))
			0: return hen_pkg::CH_LF;
			1: return hen_pkg::CH_CR;
			2: return hen_pkg::CH_AMP;
			3: return hen_pkg::CH_LT;
			4: return hen_pkg::CH_GT;
			5: return hen_pkg::CH_QUOT;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_text(input int len);
		for (int i = 0; i < len; i++)
			send_item(pick_char(), i == len - 1);
	endtask

	// stop offering, wait out every expected byte and any held-newline item
	task automatic wait_results_done();
		push <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, then read back escape_html
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == ESCAPE_ADDR)
			esc_on = data[0];
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ESCAPE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[0] !== esc_on)
			report($sformatf("escape_html read %0b, expected %0b", prdata[0], esc_on));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_escape(input logic v);
		apb_write(ESCAPE_ADDR, {31'($urandom), v});
	endtask

	// field extremes, every replacement, every newline combination
	task automatic test_directed();
		send_item("A", 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(hen_pkg::CH_AMP, 1'b0);
		send_item(hen_pkg::CH_LT, 1'b0);
		send_item(hen_pkg::CH_GT, 1'b0);
		send_item(hen_pkg::CH_QUOT, 1'b0);
		// lone newlines followed by plain bytes
		send_item(hen_pkg::CH_LF, 1'b0);
		send_item("x", 1'b0);
		send_item(hen_pkg::CH_CR, 1'b0);
		send_item("y", 1'b0);
		// merged pairs
		send_item(hen_pkg::CH_LF, 1'b0);
		send_item(hen_pkg::CH_CR, 1'b0);
		send_item(hen_pkg::CH_CR, 1'b0);
		send_item(hen_pkg::CH_LF, 1'b0);
		// same-kind newlines are held again
		send_item(hen_pkg::CH_LF, 1'b0);
		send_item(hen_pkg::CH_LF, 1'b0);
		send_item(hen_pkg::CH_CR, 1'b0);
		send_item(hen_pkg::CH_CR, 1'b0);
		// held cr then quote: longest expansion
		send_item(hen_pkg::CH_QUOT, 1'b1);
		// newline as last byte, pair closing the text, plain last byte
		send_item(hen_pkg::CH_LF, 1'b1);
		send_item(hen_pkg::CH_CR, 1'b0);
		send_item(hen_pkg::CH_LF, 1'b1);
		send_item(hen_pkg::CH_LF, 1'b0);
		send_item(hen_pkg::CH_AMP, 1'b1);
		send_item("q", 1'b1);
		wait_results_done();
	endtask

	// escape off, unused register, change in the middle of a text
	task automatic test_escape_register();
		set_escape(1'b0);
		send_item(hen_pkg::CH_AMP, 1'b0);
		send_item(hen_pkg::CH_LT, 1'b0);
		send_item(hen_pkg::CH_GT, 1'b0);
		send_item(hen_pkg::CH_QUOT, 1'b0);
		send_item(hen_pkg::CH_CR, 1'b0);
		send_item("a", 1'b1);
		wait_results_done();
		apb_write(UNUSED_ADDR, 32'hFFFF_FFFF);
		send_item(hen_pkg::CH_AMP, 1'b1);
		send_item(hen_pkg::CH_LF, 1'b0);
		wait_results_done();
		// held newline survives the register change
		set_escape(1'b1);
		send_item(hen_pkg::CH_QUOT, 1'b0);
		send_item(hen_pkg::CH_CR, 1'b0);
		wait_results_done();
		set_escape(1'b0);
		send_item(hen_pkg::CH_LT, 1'b1);
		wait_results_done();
	endtask

	// random texts over several escape settings
	task automatic test_random_texts();
		int sent;
		int len;
		for (int phase = 0; phase < 6; phase++) begin
			set_escape(phase < 4 ? phase[0] == 1'b0 : 1'($urandom));
			sent = 0;
			while (sent < 30) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
					: $urandom_range(1, 6);
				send_text(len);
				sent += len;
			end
			wait_results_done();
		end
	endtask

	// long receiver hold while the sender keeps offering
	task automatic test_backpressure();
		set_escape(1'b1);
		stall_req = LONG_STALL;
		for (int i = 0; i < 10; i++) begin
			send_item(hen_pkg::CH_CR, 1'b0);
			send_item(hen_pkg::CH_QUOT, 1'b0);
			send_item(pick_char(), i == 9);
		end
		wait_results_done();
	endtask

	// no idling on either side at the end
	task automatic test_full_rate();
		int sent;
		int len;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		sent = 0;
		while (sent < 30) begin
			len = $urandom_range(1, 8);
			send_text(len);
			sent += len;
		end
		wait_results_done();
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		out_rec_t want;
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h", out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.ch)
					report($sformatf("out_byte %02h, expected %02h", out_byte, want.ch));
				if (last_of_run !== want.run_end)
					report($sformatf("last_of_run %0b, expected %0b on byte %02h",
						last_of_run, want.run_end, want.ch));
				if (end_of_text !== want.text_end)
					report($sformatf("end_of_text %0b, expected %0b on byte %02h",
						end_of_text, want.text_end, want.ch));
			end
		end
	end

	// receiver: random stall bursts and the long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else if (stall_req > 0) begin
			pop <= 1'b0;
			stall_left = stall_req - 1;
			stall_req = 0;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			pop <= 1'b0;
			stall_left = $urandom_range(0, 7);
		end else begin
			pop <= 1'b1;
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL html_escape_newline_to_paragraph_top");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_byte = 8'h00;
		last_byte = 1'b0;
		pop = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ESCAPE_ADDR;
		pwdata = 32'h0;
		held_nl = hen_pkg::NL_NONE;
		esc_on = 1'b1;
		mismatches = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		stall_req = 0;
		stall_left = 0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_escape_register();
		test_random_texts();
		test_backpressure();
		test_full_rate();

		if (mismatches == 0)
			$display("PASS html_escape_newline_to_paragraph_top");
		else
			$display("FAIL html_escape_newline_to_paragraph_top");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/hen_pkg.sv
sv/hen_front.sv
sv/hen_queue.sv
sv/hen_back.sv
sv/html_escape_newline_to_paragraph_top.sv
bench/testbench.sv
